// ===== sv/rle_bitplane_decoder_unit_macros.svh =====
// Assertion helpers used by the decoder unit
`ifndef RLE_BITPLANE_DECODER_UNIT_MACROS_SVH
`define RLE_BITPLANE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define RBD_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, gated off during reset
`define RBD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/rbd_pkg.sv =====
package rbd_pkg;

    // Field and datapath widths
    localparam int COL_W   = 8;
    localparam int ROW_W   = 8;
    localparam int GRP_W   = 2;
    localparam int IDX_W   = 16;
    localparam int MASK_W  = 8;
    localparam int PAIR_W  = 2;
    localparam int RUN_W   = 16;
    localparam int ZERO_W  = 17;
    localparam int BL_W    = 5;
    localparam int MUL_A_W = COL_W + GRP_W;
    localparam int PROD_W  = MUL_A_W + ROW_W;
    localparam int LIN_W   = 19;
    localparam int REM_W   = ROW_W + 1;
    localparam int CNT_W   = 5;

    // Longest legal run prefix
    localparam logic [BL_W-1:0] MAX_PREFIX_ONES = 5'd15;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ROWS    = 1'b1;
    localparam logic [COL_W-1:0] COLUMNS_RESET = 8'd7;
    localparam logic [ROW_W-1:0] ROWS_RESET    = 8'd56;

    // Pair codes
    localparam logic [PAIR_W-1:0] PAIR_NONE = 2'b00;

    // Request to the position advance unit
    typedef struct packed {
        logic              start;
        logic [COL_W-1:0]  column;
        logic [GRP_W-1:0]  group;
        logic [ROW_W-1:0]  row;
        logic [ZERO_W-1:0] zeros;
    } adv_req_t;

    // Response from the position advance unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic              plane_end;
        logic [IDX_W-1:0]  index;
        logic [COL_W-1:0]  column;
        logic [GRP_W-1:0]  group;
        logic [ROW_W-1:0]  row;
    } adv_rsp_t;

endpackage

// ===== sv/rbd_advance_unit.sv =====
module rbd_advance_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rbd_pkg::COL_W-1:0] plane_columns,
    input  logic [rbd_pkg::ROW_W-1:0] plane_rows,
    input  rbd_pkg::adv_req_t         req,
    output rbd_pkg::adv_rsp_t         rsp
);

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL_IDX,
        U_MUL_POS,
        U_MUL_TOT,
        U_CHECK,
        U_DIV,
        U_DONE
    } ustate_t;

    ustate_t                       st_reg;
    logic [rbd_pkg::ZERO_W-1:0]    zeros_reg;
    logic [rbd_pkg::PROD_W-1:0]    prod_reg;
    logic [rbd_pkg::LIN_W-1:0]     lin_reg;
    logic [rbd_pkg::REM_W-1:0]     rem_reg;
    logic [rbd_pkg::CNT_W-1:0]     cnt_reg;
    logic [rbd_pkg::IDX_W-1:0]     idx_reg;
    logic                          end_reg;

    logic [rbd_pkg::MUL_A_W-1:0]   mul_a;
    logic [rbd_pkg::PROD_W-1:0]    mul_out;
    logic [rbd_pkg::REM_W-1:0]     rem_shift;
    logic                          rem_ge;
    logic [rbd_pkg::REM_W-1:0]     rem_next;
    logic [rbd_pkg::LIN_W:0]       total;

    // Select the multiplier operand for the current step
    always_comb
    begin
        unique case (st_reg)
            U_MUL_IDX: mul_a = {2'b00, req.column};
            U_MUL_POS: mul_a = {req.column, req.group};
            default:   mul_a = {2'b00, plane_columns};
        endcase
    end

    // Shared multiplier, every operand scaled by the row count
    assign mul_out = {{(rbd_pkg::PROD_W-rbd_pkg::MUL_A_W){1'b0}}, mul_a}
                   * {{(rbd_pkg::PROD_W-rbd_pkg::ROW_W){1'b0}}, plane_rows};

    // One restoring division step: bring down the next bit, subtract if it fits
    assign rem_shift = {rem_reg[rbd_pkg::REM_W-2:0], lin_reg[rbd_pkg::LIN_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, plane_rows};
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, plane_rows}) : rem_shift;

    // Number of positions in the plane: columns * 4 groups * rows
    assign total = {prod_reg, 2'b00};

    // Sequence: index multiply, position multiply, total multiply, bound check, divide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= U_IDLE;
            zeros_reg <= '0;
            prod_reg  <= '0;
            lin_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        zeros_reg <= req.zeros;
                        st_reg    <= U_MUL_IDX;
                    end
                end
                U_MUL_IDX:
                begin
                    prod_reg <= mul_out;
                    st_reg   <= U_MUL_POS;
                end
                U_MUL_POS:
                begin
                    idx_reg  <= prod_reg[rbd_pkg::IDX_W-1:0]
                              + {{(rbd_pkg::IDX_W-rbd_pkg::ROW_W){1'b0}}, req.row};
                    prod_reg <= mul_out;
                    st_reg   <= U_MUL_TOT;
                end
                U_MUL_TOT:
                begin
                    lin_reg  <= {{(rbd_pkg::LIN_W-rbd_pkg::PROD_W){1'b0}}, prod_reg}
                              + {{(rbd_pkg::LIN_W-rbd_pkg::ROW_W){1'b0}}, req.row}
                              + {{(rbd_pkg::LIN_W-rbd_pkg::ZERO_W){1'b0}}, zeros_reg};
                    prod_reg <= mul_out;
                    st_reg   <= U_CHECK;
                end
                U_CHECK:
                begin
                    // Past the last position (or no rows at all): plane ends
                    if ({1'b0, lin_reg} >= total)
                    begin
                        end_reg <= 1'b1;
                        st_reg  <= U_DONE;
                    end
                    else
                    begin
                        end_reg <= 1'b0;
                        rem_reg <= '0;
                        cnt_reg <= rbd_pkg::CNT_W'(rbd_pkg::LIN_W - 1);
                        st_reg  <= U_DIV;
                    end
                end
                U_DIV:
                begin
                    rem_reg <= rem_next;
                    lin_reg <= {lin_reg[rbd_pkg::LIN_W-2:0], rem_ge};
                    if (cnt_reg == '0)
                        st_reg <= U_DONE;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                U_DONE:
                begin
                    st_reg <= U_IDLE;
                end
                default:
                begin
                    st_reg <= U_IDLE;
                end
            endcase
        end
    end

    // Quotient is the slot (column and group), remainder is the row
    always_comb
    begin
        rsp.busy      = st_reg != U_IDLE;
        rsp.done      = st_reg == U_DONE;
        rsp.plane_end = end_reg;
        rsp.index     = idx_reg;
        rsp.column    = lin_reg[rbd_pkg::COL_W+rbd_pkg::GRP_W-1:rbd_pkg::GRP_W];
        rsp.group     = lin_reg[rbd_pkg::GRP_W-1:0];
        rsp.row       = rem_reg[rbd_pkg::ROW_W-1:0];
    end

endmodule

// ===== sv/rle_bitplane_decoder_unit.sv =====
// Run-length bitplane decoder. Takes the compressed stream one bit per item and
// emits OR-writes (buffer index and 8-bit mask) into a byte plane that is laid out
// column by column and swept in four 2-bit groups per column. An ordinary bit is
// taken and the next item can follow straight away. A bit that ends a nonzero data
// pair or the value field of a zero run moves the position in the advance unit
// (three multiplies on one shared multiplier, a bound check and a 19-step restoring
// divide by the row count); no divide is needed when the new position falls off the
// end of the plane. A result, if any, is staged and then loaded into the output
// register. An empty-plane mark or a prefix error needs no advance. While the output
// register is still full, a staged result waits and the input stays closed. Results
// carry plane_done on the last write of a plane or as a done-only mark (index and
// mask zero) when a run reaches the end, and stream_error with plane_done when a run
// prefix has more than fifteen ones. Write plane_columns and plane_rows between
// items.
`include "rle_bitplane_decoder_unit_macros.svh"

module rle_bitplane_decoder_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbd_pkg::COL_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          data_bit,
    input  logic                          begin_plane,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rbd_pkg::IDX_W-1:0]     write_index,
    output logic [rbd_pkg::MASK_W-1:0]    write_mask,
    output logic                          plane_done,
    output logic                          stream_error
);

    typedef enum logic [1:0] {
        S_READY,
        S_ADV,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PAIR_HI,
        PH_PAIR_LO,
        PH_PREFIX,
        PH_VALUE
    } phase_t;

    // Place a pair into its group: bits 7:6 for group 0 down to 1:0 for group 3
    function automatic logic [rbd_pkg::MASK_W-1:0] group_mask
    (
        input logic [rbd_pkg::PAIR_W-1:0] pair,
        input logic [rbd_pkg::GRP_W-1:0]  grp
    );
        logic [rbd_pkg::GRP_W:0] sh;
        sh = {~grp, 1'b0};
        return {{(rbd_pkg::MASK_W-rbd_pkg::PAIR_W){1'b0}}, pair} << sh;
    endfunction

    state_t                         st_reg;
    phase_t                         phase_reg;
    logic [rbd_pkg::COL_W-1:0]      plane_columns_reg;
    logic [rbd_pkg::ROW_W-1:0]      plane_rows_reg;
    logic [rbd_pkg::RUN_W-1:0]      prefix_value_reg;
    logic [rbd_pkg::RUN_W-1:0]      value_bits_reg;
    logic [rbd_pkg::BL_W-1:0]       bits_left_reg;
    logic [rbd_pkg::COL_W-1:0]      column_index_reg;
    logic [rbd_pkg::GRP_W-1:0]      group_index_reg;
    logic [rbd_pkg::ROW_W-1:0]      row_index_reg;
    logic                           first_pair_bit_reg;
    logic                           wr_mode_reg;
    logic [rbd_pkg::MASK_W-1:0]     mask_reg;
    logic [rbd_pkg::IDX_W-1:0]      res_index_reg;
    logic [rbd_pkg::MASK_W-1:0]     res_mask_reg;
    logic                           res_done_reg;
    logic                           res_error_reg;
    logic                           out_valid_reg;
    logic [rbd_pkg::IDX_W-1:0]      write_index_reg;
    logic [rbd_pkg::MASK_W-1:0]     write_mask_reg;
    logic                           plane_done_reg;
    logic                           stream_error_reg;

    logic                           accept;
    logic                           emit_load;
    logic [rbd_pkg::PAIR_W-1:0]     pair;
    logic [rbd_pkg::RUN_W-1:0]      value_next;
    logic [rbd_pkg::BL_W-1:0]       bits_left_dec;
    logic [rbd_pkg::ZERO_W-1:0]     run_zeros;
    rbd_pkg::adv_req_t              adv_req;
    rbd_pkg::adv_rsp_t              adv_rsp;

    assign in_ready  = st_reg == S_READY;
    assign accept    = in_valid && in_ready;
    assign emit_load = (st_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign pair          = {first_pair_bit_reg, data_bit};
    assign value_next    = {value_bits_reg[rbd_pkg::RUN_W-2:0], data_bit};
    assign bits_left_dec = bits_left_reg - 1'b1;
    assign run_zeros     = {1'b0, prefix_value_reg} + {1'b0, value_next}
                         + rbd_pkg::ZERO_W'(1);

    // Kick the advance unit on a data write or at the end of a run value
    always_comb
    begin
        adv_req.start  = accept && !begin_plane
                       && (((phase_reg == PH_PAIR_LO) && (pair != rbd_pkg::PAIR_NONE))
                           || ((phase_reg == PH_VALUE) && (bits_left_dec == '0)));
        adv_req.column = column_index_reg;
        adv_req.group  = group_index_reg;
        adv_req.row    = row_index_reg;
        adv_req.zeros  = (phase_reg == PH_PAIR_LO) ? rbd_pkg::ZERO_W'(1) : run_zeros;
    end

    rbd_advance_unit u_advance
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .plane_columns (plane_columns_reg),
        .plane_rows    (plane_rows_reg),
        .req           (adv_req),
        .rsp           (adv_rsp)
    );

    // Sequencer, decoder state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg             <= S_READY;
            phase_reg          <= PH_IDLE;
            plane_columns_reg  <= rbd_pkg::COLUMNS_RESET;
            plane_rows_reg     <= rbd_pkg::ROWS_RESET;
            prefix_value_reg   <= '0;
            value_bits_reg     <= '0;
            bits_left_reg      <= '0;
            column_index_reg   <= '0;
            group_index_reg    <= '0;
            row_index_reg      <= '0;
            first_pair_bit_reg <= 1'b0;
            wr_mode_reg        <= 1'b0;
            mask_reg           <= '0;
            res_index_reg      <= '0;
            res_mask_reg       <= '0;
            res_done_reg       <= 1'b0;
            res_error_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            write_index_reg    <= '0;
            write_mask_reg     <= '0;
            plane_done_reg     <= 1'b0;
            stream_error_reg   <= 1'b0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    rbd_pkg::CFG_PLANE_COLUMNS: plane_columns_reg <= cfg_data;
                    rbd_pkg::CFG_PLANE_ROWS:    plane_rows_reg    <= cfg_data;
                    default: ;
                endcase
            end

            // Load a staged item, or drop the output item once taken
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (st_reg)
                S_READY:
                begin
                    if (accept)
                    begin
                        if (begin_plane)
                        begin
                            // Start a new plane from the mode bit
                            column_index_reg   <= '0;
                            group_index_reg    <= '0;
                            row_index_reg      <= '0;
                            prefix_value_reg   <= '0;
                            value_bits_reg     <= '0;
                            bits_left_reg      <= '0;
                            first_pair_bit_reg <= 1'b0;
                            if ((plane_columns_reg == '0) || (plane_rows_reg == '0))
                            begin
                                phase_reg     <= PH_IDLE;
                                res_index_reg <= '0;
                                res_mask_reg  <= '0;
                                res_done_reg  <= 1'b1;
                                res_error_reg <= 1'b0;
                                st_reg        <= S_EMIT;
                            end
                            else if (data_bit)
                                phase_reg <= PH_PAIR_HI;
                            else
                            begin
                                phase_reg     <= PH_PREFIX;
                                bits_left_reg <= rbd_pkg::BL_W'(1);
                            end
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_IDLE: ;
                                PH_PAIR_HI:
                                begin
                                    first_pair_bit_reg <= data_bit;
                                    phase_reg          <= PH_PAIR_LO;
                                end
                                PH_PAIR_LO:
                                begin
                                    if (pair == rbd_pkg::PAIR_NONE)
                                    begin
                                        // End of data: a run packet follows
                                        phase_reg        <= PH_PREFIX;
                                        prefix_value_reg <= '0;
                                        bits_left_reg    <= rbd_pkg::BL_W'(1);
                                    end
                                    else
                                    begin
                                        mask_reg    <= group_mask(pair, group_index_reg);
                                        wr_mode_reg <= 1'b1;
                                        st_reg      <= S_ADV;
                                    end
                                end
                                PH_PREFIX:
                                begin
                                    if (data_bit)
                                    begin
                                        if (bits_left_reg > rbd_pkg::MAX_PREFIX_ONES)
                                        begin
                                            phase_reg     <= PH_IDLE;
                                            res_index_reg <= '0;
                                            res_mask_reg  <= '0;
                                            res_done_reg  <= 1'b1;
                                            res_error_reg <= 1'b1;
                                            st_reg        <= S_EMIT;
                                        end
                                        else
                                        begin
                                            prefix_value_reg <=
                                                {prefix_value_reg[rbd_pkg::RUN_W-2:1], 2'b10};
                                            bits_left_reg    <= bits_left_reg + 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        value_bits_reg <= '0;
                                        phase_reg      <= PH_VALUE;
                                    end
                                end
                                PH_VALUE:
                                begin
                                    value_bits_reg <= value_next;
                                    bits_left_reg  <= bits_left_dec;
                                    if (bits_left_dec == '0)
                                    begin
                                        wr_mode_reg <= 1'b0;
                                        st_reg      <= S_ADV;
                                    end
                                end
                                default:
                                begin
                                    phase_reg <= PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                S_ADV:
                begin
                    if (adv_rsp.done)
                    begin
                        // Hold the position when the plane has ended
                        if (!adv_rsp.plane_end)
                        begin
                            column_index_reg <= adv_rsp.column;
                            group_index_reg  <= adv_rsp.group;
                            row_index_reg    <= adv_rsp.row;
                        end
                        if (wr_mode_reg)
                        begin
                            res_index_reg <= adv_rsp.index;
                            res_mask_reg  <= mask_reg;
                            res_done_reg  <= adv_rsp.plane_end;
                            res_error_reg <= 1'b0;
                            phase_reg     <= adv_rsp.plane_end ? PH_IDLE : PH_PAIR_HI;
                            st_reg        <= S_EMIT;
                        end
                        else if (adv_rsp.plane_end)
                        begin
                            res_index_reg <= '0;
                            res_mask_reg  <= '0;
                            res_done_reg  <= 1'b1;
                            res_error_reg <= 1'b0;
                            phase_reg     <= PH_IDLE;
                            st_reg        <= S_EMIT;
                        end
                        else
                        begin
                            phase_reg <= PH_PAIR_HI;
                            st_reg    <= S_READY;
                        end
                    end
                end
                S_EMIT:
                begin
                    // Load the output register once it is free
                    if (emit_load)
                    begin
                        write_index_reg  <= res_index_reg;
                        write_mask_reg   <= res_mask_reg;
                        plane_done_reg   <= res_done_reg;
                        stream_error_reg <= res_error_reg;
                        st_reg           <= S_READY;
                    end
                end
                default:
                begin
                    st_reg <= S_READY;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_index  = write_index_reg;
    assign write_mask   = write_mask_reg;
    assign plane_done   = plane_done_reg;
    assign stream_error = stream_error_reg;

    // An error result always closes the plane and carries no write
    `RBD_ASSERT_IMPL(a_error_is_done, clk, rst_n, out_valid && stream_error,
        plane_done && (write_mask == '0) && (write_index == '0),
        "error item without done mark")
    // A result with no mask bits can only be a done mark
    `RBD_ASSERT_IMPL(a_empty_mask_done, clk, rst_n, out_valid && (write_mask == '0),
        plane_done, "empty write without done mark")
    // The input side never opens while the advance unit is working
    `RBD_ASSERT_IMPL(a_ready_unit_idle, clk, rst_n, st_reg == S_READY, !adv_rsp.busy,
        "ready while advance unit busy")
    // A started advance leaves the ready state on the next cycle
    `RBD_ASSERT_NEXT(a_start_busy, clk, rst_n, adv_req.start,
        (st_reg == S_ADV) && adv_rsp.busy, "advance start not followed")

endmodule
